/* hdl/wvm_pkg.sv */
// ----------------------------------------------------------------------------
// wvm_pkg
// Shared constants, request codes and control types of the wavetable voice
// mixer.
// ----------------------------------------------------------------------------
package wvm_pkg;

  localparam int VOICES      = 8;
  localparam int TABLE_SIZE  = 2048;
  localparam int PHASE_SHIFT = 21;
  localparam int TABLE_COUNT = 4;
  localparam int DAC_MID     = 2048;
  localparam int DAC_MAX     = 4095;

  localparam int OP_W    = 2;
  localparam int VOICE_W = 3;
  localparam int STEP_W  = 32;
  localparam int GAIN_W  = 16;
  localparam int WAVE_W  = 3;
  localparam int SEL_W   = 2;
  localparam int INDEX_W = 11;
  localparam int WORD_W  = 16;
  localparam int DAC_W   = 12;

  localparam int VIDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int TIDX_W      = $clog2(TABLE_SIZE);
  localparam int ADDR_W      = $clog2(TABLE_COUNT * TABLE_SIZE);
  localparam int SCALE_SHIFT = 12;
  localparam int PROD_W      = WORD_W + GAIN_W + 1;
  localparam int TERM_W      = PROD_W - SCALE_SHIFT;
  localparam int MIX_W       = TERM_W + VIDX_W + 1;
  localparam int NOISE_BITS  = 12;

  localparam logic [WAVE_W-1:0] NOISE_WAVE = WAVE_W'(4);
  localparam logic [31:0]       NOISE_SEED = 32'h0000_ACE1;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON     = 2'd0,
    OP_NOTE_OFF    = 2'd1,
    OP_TICK        = 2'd2,
    OP_TABLE_WRITE = 2'd3
  } op_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

/* hdl/wvm_if.sv */
// ----------------------------------------------------------------------------
// wvm_in_if / wvm_out_if
// Valid/ready channels carrying mixer requests and mixed DAC samples.
// ----------------------------------------------------------------------------
interface wvm_in_if;
  import wvm_pkg::*;

  logic                  valid;
  logic                  ready;
  op_t                   operation;
  logic [VOICE_W-1:0]    voice;
  logic [STEP_W-1:0]     phase_step;
  logic [GAIN_W-1:0]     amplitude;
  logic [WAVE_W-1:0]     wave;
  logic [SEL_W-1:0]      table_select;
  logic [INDEX_W-1:0]    table_index;
  logic signed [WORD_W-1:0] table_value;

  modport source (output valid, operation, voice, phase_step, amplitude, wave,
                  table_select, table_index, table_value, input ready);
  modport sink   (input valid, operation, voice, phase_step, amplitude, wave,
                  table_select, table_index, table_value, output ready);
endinterface

interface wvm_out_if;
  import wvm_pkg::*;

  logic             valid;
  logic             ready;
  logic [DAC_W-1:0] dac_sample;

  modport source (output valid, dac_sample, input ready);
  modport sink   (input valid, dac_sample, output ready);
endinterface

/* hdl/wavetable_voice_mixer_core.sv */
// ----------------------------------------------------------------------------
// wavetable_voice_mixer_core
// Polyphonic wavetable oscillator bank and mixer for a 12-bit DAC.
// ----------------------------------------------------------------------------
// Note on, note off and table write requests complete in the cycle they are
// accepted and give no output. A sample tick walks the voices in slot order
// through one shared multiply-accumulate unit: an active voice goes through
// phase update with table read, multiply and accumulate, an inactive one is
// skipped, and a final step loads the clamped mix into the output register
// as soon as that register is free. The registered read of the wave table
// memory and the single multiplier set these steps. The input is not ready
// while a tick is in progress; a finished sample waits in the output register
// without holding up new requests. Wave table words are undefined until
// written.
// ----------------------------------------------------------------------------
module wavetable_voice_mixer_core (
  input  logic        clk,
  input  logic        rst,
  wvm_in_if.sink      req,
  wvm_out_if.source   res
);
  import wvm_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_MUL, ST_ACC, ST_OUT} state_t;
  typedef enum logic [1:0] {SRC_TABLE, SRC_NOISE, SRC_ZERO} src_t;

  state_t                   state;
  src_t                     src;
  logic [VIDX_W-1:0]        vidx;
  logic signed [WORD_W-1:0] noise_sample;

  logic [STEP_W-1:0] phase [VOICES];
  logic [STEP_W-1:0] step  [VOICES];
  logic [GAIN_W-1:0] gain  [VOICES];
  logic [WAVE_W-1:0] kind  [VOICES];
  logic [VOICES-1:0] active;
  logic [31:0]       noise;

  logic [31:0]              noise_next;
  logic [STEP_W-1:0]        phase_next;
  logic                     accept;
  logic                     voice_ok;
  logic                     is_last;
  logic                     tbl_we;
  logic [ADDR_W-1:0]        waddr;
  logic [ADDR_W-1:0]        raddr;
  logic [TIDX_W-1:0]        tidx;
  logic [WORD_W-1:0]        rdata;
  logic signed [WORD_W-1:0] sample;
  logic [VIDX_W-1:0]        vslot;
  mac_ctrl_t                mac_ctrl;
  logic [DAC_W-1:0]         dac;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign voice_ok  = 32'(req.voice) < VOICES;
  assign vslot     = VIDX_W'(req.voice);
  assign is_last   = (vidx == VIDX_W'(VOICES - 1));

  always_comb begin
    logic [31:0] s;
    s = noise;
    s = s ^ (s >> 1);
    s = s ^ (s << 5);
    s = s ^ (s >> 14);
    noise_next = s;
  end

  assign phase_next = phase[vidx] + step[vidx];
  assign tidx       = TIDX_W'((phase_next >> PHASE_SHIFT) % TABLE_SIZE);
  assign raddr      = ADDR_W'(kind[vidx]) * ADDR_W'(TABLE_SIZE) + ADDR_W'(tidx);

  assign tbl_we = accept && (req.operation == OP_TABLE_WRITE)
                  && (32'(req.table_select) < TABLE_COUNT)
                  && (32'(req.table_index) < TABLE_SIZE);
  assign waddr  = ADDR_W'(req.table_select) * ADDR_W'(TABLE_SIZE)
                  + ADDR_W'(req.table_index);

  always_comb begin
    case (src)
      SRC_TABLE: sample = $signed(rdata);
      SRC_NOISE: sample = noise_sample;
      default:   sample = '0;
    endcase
  end

  assign mac_ctrl.clear  = accept && (req.operation == OP_TICK);
  assign mac_ctrl.mul_en = (state == ST_MUL);
  assign mac_ctrl.acc_en = (state == ST_ACC);

  wvm_wave_ram u_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (waddr),
    .wdata (req.table_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  wvm_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .sample (sample),
    .gain   (gain[vidx]),
    .dac    (dac)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        phase[i] <= '0;
        step[i]  <= '0;
        gain[i]  <= '0;
        kind[i]  <= '0;
      end
      active <= '0;
      noise  <= NOISE_SEED;
    end else begin
      if (accept && voice_ok && (req.operation == OP_NOTE_ON)) begin
        step[vslot]   <= req.phase_step;
        gain[vslot]   <= req.amplitude;
        kind[vslot]   <= req.wave;
        phase[vslot]  <= '0;
        active[vslot] <= 1'b1;
      end
      if (accept && voice_ok && (req.operation == OP_NOTE_OFF)) begin
        active[vslot] <= 1'b0;
      end
      if ((state == ST_FETCH) && active[vidx]) begin
        phase[vidx] <= phase_next;
        if (kind[vidx] == NOISE_WAVE) begin
          noise <= noise_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vidx      <= '0;
      src       <= SRC_ZERO;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && (state != ST_OUT)) begin
        res.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (req.operation == OP_TICK)) begin
            vidx  <= '0;
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          if (active[vidx]) begin
            if (kind[vidx] == NOISE_WAVE) begin
              src <= SRC_NOISE;
            end else if (32'(kind[vidx]) < TABLE_COUNT) begin
              src <= SRC_TABLE;
            end else begin
              src <= SRC_ZERO;
            end
            noise_sample <= WORD_W'($signed({~noise_next[NOISE_BITS-1],
                                             noise_next[NOISE_BITS-2:0]}));
            state <= ST_MUL;
          end else if (is_last) begin
            state <= ST_OUT;
          end else begin
            vidx <= vidx + 1'b1;
          end
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (is_last) begin
            state <= ST_OUT;
          end else begin
            vidx  <= vidx + 1'b1;
            state <= ST_FETCH;
          end
        end
        ST_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid      <= 1'b1;
            res.dac_sample <= dac;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_out_from_mix: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == ST_OUT)
    else $error("output raised outside the output step");

  a_noise_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(state) != ST_FETCH) |-> $stable(noise))
    else $error("noise generator advanced outside a voice fetch");

  a_skip_idle_voice: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH && !active[vidx] && !is_last) |=> state == ST_FETCH)
    else $error("inactive voice not skipped");

  a_acc_after_mul: assert property (@(posedge clk) disable iff (rst)
    mac_ctrl.acc_en |-> $past(mac_ctrl.mul_en))
    else $error("accumulate without a preceding multiply");

endmodule

/* hdl/wvm_wave_ram.sv */
// ----------------------------------------------------------------------------
// wvm_wave_ram
// Wave table store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wvm_wave_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [wvm_pkg::ADDR_W-1:0]  waddr,
  input  logic [wvm_pkg::WORD_W-1:0]  wdata,
  input  logic [wvm_pkg::ADDR_W-1:0]  raddr,
  output logic [wvm_pkg::WORD_W-1:0]  rdata
);
  import wvm_pkg::*;

  logic [WORD_W-1:0] mem [TABLE_COUNT * TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/wvm_mac.sv */
// ----------------------------------------------------------------------------
// wvm_mac
// Shared multiply-accumulate: scales one voice sample by its gain, floors by
// 2^12 into the mix, and offsets and clamps the mix for the DAC.
// ----------------------------------------------------------------------------
module wvm_mac (
  input  logic                               clk,
  input  wvm_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [wvm_pkg::WORD_W-1:0]  sample,
  input  logic [wvm_pkg::GAIN_W-1:0]         gain,
  output logic [wvm_pkg::DAC_W-1:0]          dac
);
  import wvm_pkg::*;

  logic signed [GAIN_W:0]   gain_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [MIX_W-1:0]  acc;
  logic signed [MIX_W:0]    sum;
  logic signed [MIX_W:0]    clamped;

  assign gain_s = $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= sample * gain_s;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + MIX_W'(prod >>> SCALE_SHIFT);
    end
  end

  always_comb begin
    sum = (MIX_W + 1)'(acc) + (MIX_W + 1)'(DAC_MID);
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > DAC_MAX) begin
      clamped = (MIX_W + 1)'(DAC_MAX);
    end else begin
      clamped = sum;
    end
  end

  assign dac = clamped[DAC_W-1:0];

endmodule
